// ===== rtl/base64_stream_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// Concurrent check wrappers, compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// property must hold on every clock edge outside reset
`define B64SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen on a clock edge outside reset
`define B64SD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define B64SD_ASSERT(lbl, prop, msg)
`define B64SD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// Shared types and codes of the base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_BADPAD  = 3'd2,
    ST_DONE    = 3'd3,
    ST_MISSING = 3'd4,
    ST_HALTED  = 3'd5
  } status_e;

  // character class after the front stage
  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_SPACE,
    KIND_PAD,
    KIND_BAD,
    KIND_END
  } kind_e;

  // one classified request in the queue
  typedef struct packed {
    kind_e      kind;
    logic [5:0] sym;
  } item_t;

  // queue fill flags
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // decoder status toward the top
  typedef struct packed {
    logic halted;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/b64sd_char_if.sv =====
// ----------------------------------------------------------------------------
// b64sd_char_if
// Input channel: one text character or an end-of-input mark per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64sd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/b64sd_byte_if.sv =====
// ----------------------------------------------------------------------------
// b64sd_byte_if
// Output channel: up to three decoded bytes and a status per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] byte_c;
  logic [1:0] byte_count;
  logic [2:0] status;

  modport source (output valid, output byte_a, output byte_b, output byte_c,
                  output byte_count, output status, input ready);
  modport sink   (input valid, input byte_a, input byte_b, input byte_c,
                  input byte_count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/b64sd_front.sv =====
// ----------------------------------------------------------------------------
// b64sd_front
// Accepts characters and maps each to a symbol class and a 6-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_front
  import b64sd_pkg::*;
(
  b64sd_char_if.sink  char_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output item_t       item_o
);

  // base64 alphabet lookup
  function automatic item_t classify(input logic [7:0] c);
    item_t      it;
    logic [7:0] diff;
    it.kind = KIND_BAD;
    it.sym  = 6'd0;
    diff    = 8'd0;
    if (c >= "A" && c <= "Z") begin
      diff    = c - 8'd65;
      it.kind = KIND_DATA;
      it.sym  = diff[5:0];
    end else if (c >= "a" && c <= "z") begin
      diff    = c - 8'd71;
      it.kind = KIND_DATA;
      it.sym  = diff[5:0];
    end else if (c >= "0" && c <= "9") begin
      diff    = c + 8'd4;
      it.kind = KIND_DATA;
      it.sym  = diff[5:0];
    end else if (c == "+") begin
      it.kind = KIND_DATA;
      it.sym  = 6'd62;
    end else if (c == "/") begin
      it.kind = KIND_DATA;
      it.sym  = 6'd63;
    end else if (c == "=") begin
      it.kind = KIND_PAD;
    end else if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
      it.kind = KIND_SPACE;
    end
    return it;
  endfunction

  // handshake: take a request whenever the queue has room
  assign char_i.ready = !q_stat_i.full;
  assign push_o       = char_i.valid && !q_stat_i.full;

  // classification, end of input overrides the character
  always_comb begin
    if (char_i.end_of_input) begin
      item_o.kind = KIND_END;
      item_o.sym  = 6'd0;
    end else begin
      item_o = classify(char_i.in_char);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64sd_queue.sv =====
// ----------------------------------------------------------------------------
// b64sd_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_queue
  import b64sd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       item_i,
  input  logic        pop_i,
  output item_t       item_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64sd_back.sv =====
// ----------------------------------------------------------------------------
// b64sd_back
// Group and pad state machine with the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_back
  import b64sd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  queue_stat_t q_stat_i,
  output logic        pop_o,
  output back_stat_t  stat_o,
  b64sd_byte_if.source bytes_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] bits_q, bits_d;
  logic        pad_q, pad_d;
  logic [1:0]  foot_q, foot_d;
  logic        halt_q, halt_d;

  logic        out_valid_q;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic [1:0]  cnt_q, cnt_d;
  status_e     st_q, st_d;
  logic [23:0] full_word;

  // take the head request when the result register is free or drains
  assign pop_o         = !q_stat_i.empty && (!out_valid_q || bytes_o.ready);
  assign stat_o.halted = halt_q;
  assign full_word     = {bits_q, item_i.sym};

  // decode step for the head request
  always_comb begin
    pos_d  = pos_q;
    bits_d = bits_q;
    pad_d  = pad_q;
    foot_d = foot_q;
    halt_d = halt_q;
    a_d    = 8'd0;
    b_d    = 8'd0;
    c_d    = 8'd0;
    cnt_d  = 2'd0;
    st_d   = ST_OK;
    if (halt_q) begin
      st_d = ST_HALTED;
    end else begin
      unique case (item_i.kind)
        KIND_END: begin
          halt_d = 1'b1;
          st_d   = ST_MISSING;
        end
        KIND_SPACE: begin
          st_d = ST_OK;
        end
        KIND_BAD: begin
          halt_d = 1'b1;
          st_d   = ST_BADCHAR;
        end
        KIND_PAD: begin
          if (pad_q) begin
            // second pad closes a one-byte group
            pad_d  = 1'b0;
            pos_d  = 2'd0;
            bits_d = 18'd0;
          end else begin
            unique case (pos_q)
              2'd0: begin
                // footer run at a group boundary
                if (foot_q == 2'd3) begin
                  foot_d = 2'd0;
                  halt_d = 1'b1;
                  st_d   = ST_DONE;
                end else begin
                  foot_d = foot_q + 2'd1;
                end
              end
              2'd1: begin
                halt_d = 1'b1;
                st_d   = ST_BADPAD;
              end
              2'd2: begin
                a_d   = bits_q[11:4];
                cnt_d = 2'd1;
                pad_d = 1'b1;
              end
              default: begin
                a_d    = bits_q[17:10];
                b_d    = bits_q[9:2];
                cnt_d  = 2'd2;
                pos_d  = 2'd0;
                bits_d = 18'd0;
              end
            endcase
          end
        end
        KIND_DATA: begin
          if (pad_q || foot_q != 2'd0) begin
            halt_d = 1'b1;
            st_d   = ST_BADPAD;
          end else if (pos_q == 2'd3) begin
            a_d    = full_word[23:16];
            b_d    = full_word[15:8];
            c_d    = full_word[7:0];
            cnt_d  = 2'd3;
            pos_d  = 2'd0;
            bits_d = 18'd0;
          end else begin
            bits_d = {bits_q[11:0], item_i.sym};
            pos_d  = pos_q + 2'd1;
          end
        end
        default: begin
          halt_d = 1'b1;
          st_d   = ST_BADCHAR;
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      bits_q <= 18'd0;
      pad_q  <= 1'b0;
      foot_q <= 2'd0;
      halt_q <= 1'b0;
    end else if (pop_o) begin
      pos_q  <= pos_d;
      bits_q <= bits_d;
      pad_q  <= pad_d;
      foot_q <= foot_d;
      halt_q <= halt_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (bytes_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  assign bytes_o.valid      = out_valid_q;
  assign bytes_o.byte_a     = a_q;
  assign bytes_o.byte_b     = b_q;
  assign bytes_o.byte_c     = c_q;
  assign bytes_o.byte_count = cnt_q;
  assign bytes_o.status     = st_q;

endmodule

`default_nettype wire

// ===== rtl/base64_stream_decoder_top.sv =====
// Streaming base64 decoder. Each request on char_i carries one text character
// (or an end-of-input mark) and yields exactly one request on bytes_o with up to
// three decoded bytes, a byte count and a status. Whitespace gives an empty ok
// result, a four-pad footer ends the stream and any error or end halts the
// decoder until reset. One character is taken every clock cycle while the queue
// has room: the front classifies it into a small queue, and the back decoder
// retires one queued entry per cycle into the result register while it is free
// or drains, so a result is held in a queue entry and then the result register
// before bytes_o offers it, and the queue absorbs output stalls until it fills.
// The QueueDepth entries set how long the input flows after bytes_o stalls.
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Top level: front classifier, request queue and back decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_decoder_top_defines.svh"

module base64_stream_decoder_top
  import b64sd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64sd_char_if.sink    char_i,
  b64sd_byte_if.source  bytes_o
);

  queue_stat_t q_stat;
  back_stat_t  back_stat;
  logic        push;
  logic        pop;
  item_t       push_item;
  item_t       head_item;

  // character classification
  b64sd_front u_front (
    .char_i   (char_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  // decoupling queue
  b64sd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // decode state and result register
  b64sd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (head_item),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .stat_o   (back_stat),
    .bytes_o  (bytes_o)
  );

  // checks
  `B64SD_ASSERT(a_halt_sticky, back_stat.halted |=> back_stat.halted, "decoder left halt")
  `B64SD_ASSERT(a_halt_empty,
    (bytes_o.valid && bytes_o.status == ST_HALTED) |-> (bytes_o.byte_count == 2'd0),
    "halted result carries bytes")
  `B64SD_ASSERT(a_byte_c_zero,
    (bytes_o.valid && bytes_o.byte_count != 2'd3) |-> (bytes_o.byte_c == 8'd0),
    "unused third byte not zero")
  `B64SD_ASSERT_NEVER(a_full_ready, q_stat.full && char_i.ready,
    "input ready while queue full")

endmodule

`default_nettype wire
